FILE: sv/vqnce_pkg.sv
`default_nettype none

package vqnce_pkg;

  // defaults for the top level parameters
  localparam int unsigned DEPTH_DEFAULT       = 256;
  localparam int unsigned COORD_BITS_DEFAULT  = 9;
  localparam int unsigned MAX_COORD_BITS      = 16;

  // block geometry and field widths
  localparam int unsigned TEXELS     = 4;
  localparam int unsigned COMPS      = 3;
  localparam int unsigned COMP_W     = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TEXEL_W    = COMPS * BYTE_W;
  localparam int unsigned WORD_W     = COMPS * COMP_W;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CODEWORD_W = 8;
  localparam int unsigned DIST_W     = 36;
  localparam int unsigned OFS_W      = 18;

  // queue between front and back, power of two so the pointers wrap
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_ENCODE = 1'b1
  } req_t;

  // one classified item, as it travels from front to back
  typedef struct packed {
    req_t                              req;
    logic [ENTRY_W-1:0]                entry;
    logic [SLOT_W-1:0]                 slot;
    logic [WORD_W-1:0]                 word;
    logic [TEXELS-1:0][TEXEL_W-1:0]    texels;
    logic [OFS_W-1:0]                  offset;
  } qitem_t;

endpackage

`default_nettype wire

FILE: sv/vqnce_in_if.sv
`default_nettype none

interface vqnce_in_if import vqnce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ENTRY_W-1:0]   entry_index;
  logic [SLOT_W-1:0]    texel_slot;
  logic [COMP_W-1:0]    load_red;
  logic [COMP_W-1:0]    load_green;
  logic [COMP_W-1:0]    load_blue;
  logic [COORD_W-1:0]   block_x;
  logic [COORD_W-1:0]   block_y;
  logic [TEXEL_W-1:0]   texel_zero;
  logic [TEXEL_W-1:0]   texel_one;
  logic [TEXEL_W-1:0]   texel_two;
  logic [TEXEL_W-1:0]   texel_three;

  modport source (
    output valid, req_type, entry_index, texel_slot, load_red, load_green, load_blue,
    output block_x, block_y, texel_zero, texel_one, texel_two, texel_three,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, texel_slot, load_red, load_green, load_blue,
    input  block_x, block_y, texel_zero, texel_one, texel_two, texel_three,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/vqnce_out_if.sv
`default_nettype none

interface vqnce_out_if import vqnce_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CODEWORD_W-1:0]  codeword;
  logic [DIST_W-1:0]      best_distance;
  logic [OFS_W-1:0]       twiddled_offset;

  modport source (
    output valid, codeword, best_distance, twiddled_offset,
    input  ready
  );

  modport sink (
    input  valid, codeword, best_distance, twiddled_offset,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/vqnce_cfg_if.sv
`default_nettype none

interface vqnce_cfg_if import vqnce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_W-1:0]  entries_in_use;

  modport source (
    output valid, entries_in_use,
    input  ready
  );

  modport sink (
    input  valid, entries_in_use,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/vq_block_nearest_codeword_encoder_unit.sv
// channel   dir  transfer when           payload
// cfg_ch    in   valid & ready           entries_in_use
// in_ch     in   valid & ready           load texel or encode block
// out_ch    out  valid & ready           codeword, best_distance, twiddled_offset
//
// a load writes one slot of one entry in the back end
// an encode scans entries_in_use entries, one codebook entry read per cycle from the
// four slot memories, then drains the distance pipeline and hands over to the output register
// reset clears control only; codebook contents are undefined until loaded
// a queue of two items lets the front keep accepting while the back end scans
// a waiting result sits in the output register; loads go on behind it
`default_nettype none

module vq_block_nearest_codeword_encoder_unit import vqnce_pkg::*; #(
  parameter int unsigned CODEBOOK_DEPTH = DEPTH_DEFAULT,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  vqnce_cfg_if.sink    cfg_ch,
  vqnce_in_if.sink     in_ch,
  vqnce_out_if.source  out_ch
);

  logic    push_valid;
  logic    push_ready;
  qitem_t  push_item;
  logic    pop_valid;
  logic    pop_ready;
  qitem_t  pop_item;

  // classify and compute the block address
  vqnce_front #(
    .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
    .COORD_BITS     (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // decoupling queue
  vqnce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // codebook store and nearest entry search
  vqnce_back #(
    .CODEBOOK_DEPTH (CODEBOOK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/vqnce_ram.sv
`default_nettype none

module vqnce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/vqnce_front.sv
`default_nettype none

module vqnce_front import vqnce_pkg::*; #(
  parameter int unsigned CODEBOOK_DEPTH = DEPTH_DEFAULT,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vqnce_in_if.sink   in_ch,
  output logic       push_valid,
  output qitem_t     push_item,
  input  wire logic  push_ready
);

  localparam int unsigned LIM_W = ENTRY_W + 1;

  logic   valid_r, valid_nxt;
  qitem_t item_r, item_nxt;
  logic   accept;
  logic   keep;

  // interleave block coordinates, y in even bits, x in odd bits
  function automatic logic [OFS_W-1:0] twiddle(input logic [COORD_W-1:0] bx,
                                               input logic [COORD_W-1:0] by);
    logic [MAX_COORD_BITS-1:0]   xe;
    logic [MAX_COORD_BITS-1:0]   ye;
    logic [2*MAX_COORD_BITS-1:0] wide;
    xe   = MAX_COORD_BITS'(bx);
    ye   = MAX_COORD_BITS'(by);
    wide = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      wide[2*b]   = ye[b];
      wide[2*b+1] = xe[b];
    end
    return OFS_W'(wide);
  endfunction

  // classify: encodes always go on, loads only when the entry exists
  always_comb begin
    item_nxt.req    = req_t'(in_ch.req_type);
    item_nxt.entry  = in_ch.entry_index;
    item_nxt.slot   = in_ch.texel_slot;
    item_nxt.word   = {in_ch.load_red, in_ch.load_green, in_ch.load_blue};
    item_nxt.texels = {in_ch.texel_three, in_ch.texel_two, in_ch.texel_one, in_ch.texel_zero};
    item_nxt.offset = twiddle(in_ch.block_x, in_ch.block_y);
    keep = (item_nxt.req == REQ_ENCODE) ||
           ({1'b0, in_ch.entry_index} < LIM_W'(CODEBOOK_DEPTH));
  end

  assign in_ch.ready = !valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // holding register in front of the queue
  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && push_ready) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

`default_nettype wire

FILE: sv/vqnce_queue.sv
`default_nettype none

module vqnce_queue import vqnce_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  input  wire qitem_t  push_item,
  output logic         push_ready,
  output logic         pop_valid,
  output qitem_t       pop_item,
  input  wire logic    pop_ready
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (level_r != LVL_W'(QUEUE_DEPTH));
  assign pop_valid  = (level_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // fill level
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/vqnce_back.sv
`default_nettype none

module vqnce_back import vqnce_pkg::*; #(
  parameter int unsigned CODEBOOK_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    pop_valid,
  input  wire qitem_t  pop_item,
  output logic         pop_ready,
  vqnce_cfg_if.sink    cfg_ch,
  vqnce_out_if.source  out_ch
);

  localparam int unsigned IDX_W  = $clog2(CODEBOOK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(CODEBOOK_DEPTH + 1);
  localparam int unsigned LANES  = TEXELS * COMPS;
  localparam int unsigned SQ_W   = 2 * COMP_W;
  localparam int unsigned GRP_W  = SQ_W + 2;
  localparam int unsigned STAGES = 5;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_cfg;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                scan_last;
  logic                rd_en;
  logic                load_wr;
  logic                start;
  logic                out_load;

  logic [COMP_W-1:0]   px_r   [LANES];
  logic [OFS_W-1:0]    ofs_r;
  logic [WORD_W-1:0]   rd_data [TEXELS];

  logic [STAGES-1:0]   pv_r;
  logic [STAGES-1:0]   plast_r;
  logic [IDX_W-1:0]    pidx_r [STAGES];
  logic [COMP_W-1:0]   diff_r [LANES];
  logic [SQ_W-1:0]     sq_r   [LANES];
  logic [GRP_W-1:0]    grp_r  [COMPS];
  logic [DIST_W-1:0]   dist_r;
  logic [DIST_W-1:0]   best_r;
  logic [IDX_W-1:0]    best_idx_r;

  logic                   out_valid_r;
  logic [CODEWORD_W-1:0]  out_code_r;
  logic [DIST_W-1:0]      out_dist_r;
  logic [OFS_W-1:0]       out_ofs_r;

  // entry count register, clamped to 1 .. depth when written
  always_comb begin
    if (cfg_ch.entries_in_use == '0) begin
      count_cfg = CNT_W'(1);
    end else if (cfg_ch.entries_in_use > CFG_W'(CODEBOOK_DEPTH)) begin
      count_cfg = CNT_W'(CODEBOOK_DEPTH);
    end else begin
      count_cfg = CNT_W'(cfg_ch.entries_in_use);
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(CODEBOOK_DEPTH);
    end else if (cfg_ch.valid) begin
      count_r <= count_cfg;
    end
  end

  // sequencer: loads in idle, encodes scan the codebook one entry a cycle
  assign scan_last = (CNT_W'(cnt_r) == count_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    load_wr   = 1'b0;
    start     = 1'b0;
    out_load  = 1'b0;
    pop_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_item.req == REQ_ENCODE) begin
            start     = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + IDX_W'(1);
        if (scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pv_r[STAGES-1] && plast_r[STAGES-1]) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  // block texels scaled to 8.8, held for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      for (int t = 0; t < TEXELS; t++) begin
        for (int c = 0; c < COMPS; c++) begin
          px_r[t*COMPS+c] <= {pop_item.texels[t][TEXEL_W-1-BYTE_W*c -: BYTE_W],
                              {BYTE_W{1'b0}}};
        end
      end
      ofs_r <= pop_item.offset;
    end
  end

  // one codebook memory per texel slot, so all four slots of an entry are read together
  for (genvar g = 0; g < TEXELS; g++) begin : g_slot
    vqnce_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CODEBOOK_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (load_wr && (pop_item.slot == SLOT_W'(g))),
      .wr_addr (pop_item.entry[IDX_W-1:0]),
      .wr_data (pop_item.word),
      .rd_en   (rd_en),
      .rd_addr (cnt_r),
      .rd_data (rd_data[g])
    );
  end

  // stage control: valid, entry index and last flag follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[STAGES-2:0], rd_en};
    end
  end

  always_ff @(posedge clk) begin
    plast_r   <= {plast_r[STAGES-2:0], scan_last};
    pidx_r[0] <= cnt_r;
    for (int s = 1; s < STAGES; s++) begin
      pidx_r[s] <= pidx_r[s-1];
    end
  end

  // absolute differences, twelve lanes
  always_ff @(posedge clk) begin
    for (int t = 0; t < TEXELS; t++) begin
      for (int c = 0; c < COMPS; c++) begin
        if (px_r[t*COMPS+c] >= rd_data[t][WORD_W-1-COMP_W*c -: COMP_W]) begin
          diff_r[t*COMPS+c] <= px_r[t*COMPS+c] - rd_data[t][WORD_W-1-COMP_W*c -: COMP_W];
        end else begin
          diff_r[t*COMPS+c] <= rd_data[t][WORD_W-1-COMP_W*c -: COMP_W] - px_r[t*COMPS+c];
        end
      end
    end
  end

  // squares, one multiplier per lane
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      sq_r[l] <= SQ_W'(diff_r[l]) * SQ_W'(diff_r[l]);
    end
  end

  // adder tree: groups of four, then the three group sums
  always_ff @(posedge clk) begin
    for (int g = 0; g < COMPS; g++) begin
      grp_r[g] <= GRP_W'(sq_r[4*g])   + GRP_W'(sq_r[4*g+1]) +
                  GRP_W'(sq_r[4*g+2]) + GRP_W'(sq_r[4*g+3]);
    end
    dist_r <= DIST_W'(grp_r[0]) + DIST_W'(grp_r[1]) + DIST_W'(grp_r[2]);
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (pv_r[STAGES-1] && ((pidx_r[STAGES-1] == '0) || (dist_r < best_r))) begin
      best_r     <= dist_r;
      best_idx_r <= pidx_r[STAGES-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= CODEWORD_W'(best_idx_r);
      out_dist_r <= best_r;
      out_ofs_r  <= ofs_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.codeword        = out_code_r;
  assign out_ch.best_distance   = out_dist_r;
  assign out_ch.twiddled_offset = out_ofs_r;

`ifndef SYNTHESIS
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(cnt_r) < count_r))
    else $error("codebook read beyond the entry count");

  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r != '0) |-> (state_r == ST_SCAN || state_r == ST_FLUSH))
    else $error("distance pipeline busy outside a scan");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DONE) |-> $past(pv_r[STAGES-1] && plast_r[STAGES-1]))
    else $error("search finished before the last entry was compared");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without a finished search");
`endif

endmodule

`default_nettype wire
